// ===== rtl/core/mrmt_pkg.sv =====
// shared types and constants for the memory region map table
// no dependencies
package mrmt_pkg;

    localparam int MAX_REGIONS = 128;
    localparam int PAGE_BITS   = 12;

    localparam int IDX_W   = $clog2(MAX_REGIONS);
    localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W  = 64;
    localparam int KIND_W  = 32;
    localparam int PAGE_W  = 52;

    localparam logic [PAGE_W-1:0] PAGE_CAP = PAGE_W'(1) << (32 - PAGE_BITS);

    // operation codes
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CLEAR   = 3'd1;
    localparam logic [2:0] OP_CHECK   = 3'd2;
    localparam logic [2:0] OP_RETYPE  = 3'd3;
    localparam logic [2:0] OP_REMOVE  = 3'd4;
    localparam logic [2:0] OP_ENDPAGE = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_WRAP = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic [2:0]        operation;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_size;
        logic [ADDR_W-1:0] range_end;
        logic [KIND_W-1:0] entry_type;
        logic [KIND_W-1:0] repl_kind;
        logic              kind_only;
        logic [PAGE_W-1:0] limit_page;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]        status;
        logic              covered;
        logic [ADDR_W-1:0] total_bytes;
        logic [PAGE_W-1:0] last_page;
    } t_res_word;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;
        logic [KIND_W-1:0] kind;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== rtl/core/mrmt_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module mrmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mrmt_engine.sv =====
// command sequencer and per-entry evaluation for the region table
// depends on mrmt_pkg; drives the entry ram through a t_ram_req word
module mrmt_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  mrmt_pkg::t_cmd_word i_cmd,
    input  mrmt_pkg::t_entry    i_rd_entry,
    output logic                o_busy,
    output logic                o_valid,
    output mrmt_pkg::t_res_word o_res,
    output mrmt_pkg::t_ram_req  o_ram
);

    mrmt_pkg::t_state    r_state, n_state;
    logic [mrmt_pkg::CNT_W-1:0]  r_count, n_count;
    logic [mrmt_pkg::IDX_W-1:0]  r_eidx, n_eidx;
    mrmt_pkg::t_cmd_word r_cmd, n_cmd;
    logic [mrmt_pkg::ADDR_W-1:0] r_lim, n_lim;
    logic [mrmt_pkg::ADDR_W-1:0] r_point, n_point;
    logic [mrmt_pkg::ADDR_W-1:0] r_total, n_total;
    logic [mrmt_pkg::PAGE_W-1:0] r_last, n_last;
    logic                r_valid, n_valid;
    mrmt_pkg::t_res_word r_res, n_res;

    logic accept;
    logic in_walk_op;
    logic add_wrap;
    logic add_full;
    logic add_ok;
    logic go_walk;

    // per-entry evaluation
    logic [mrmt_pkg::ADDR_W-1:0] e_end;
    logic                        last_ent;
    logic                        chk_kind_ok;
    logic                        chk_ovl;
    logic [mrmt_pkg::ADDR_W-1:0] chk_point;
    logic                        chk_hit;
    logic                        sw_match_kind;
    logic                        sw_hit;
    logic [mrmt_pkg::ADDR_W-1:0] sp64, ep64, lim64;
    logic                        ep_ok;
    logic                        ep_brk;
    logic [mrmt_pkg::PAGE_W-1:0] ep_last;
    logic [mrmt_pkg::PAGE_W-1:0] pg_fin;
    logic                        done_w;
    logic                        is_sweep;

    assign accept     = i_start && (r_state == mrmt_pkg::ST_IDLE);
    assign in_walk_op = (i_cmd.operation == mrmt_pkg::OP_CHECK)
                     || (i_cmd.operation == mrmt_pkg::OP_RETYPE)
                     || (i_cmd.operation == mrmt_pkg::OP_REMOVE)
                     || (i_cmd.operation == mrmt_pkg::OP_ENDPAGE);
    assign add_wrap   = (i_cmd.range_size != '0)
                     && (i_cmd.range_start >
                         (i_cmd.range_start + i_cmd.range_size - 64'd1));
    assign add_full   = (r_count >= mrmt_pkg::CNT_W'(mrmt_pkg::MAX_REGIONS));
    assign add_ok     = (i_cmd.operation == mrmt_pkg::OP_ADD) && !add_wrap && !add_full;
    assign go_walk    = accept && in_walk_op && (r_count != '0);

    assign e_end    = i_rd_entry.addr + i_rd_entry.len;
    assign last_ent = ((mrmt_pkg::CNT_W'(r_eidx) + mrmt_pkg::CNT_W'(1)) == r_count);
    assign is_sweep = (r_cmd.operation == mrmt_pkg::OP_RETYPE)
                   || (r_cmd.operation == mrmt_pkg::OP_REMOVE);

    // coverage check
    assign chk_kind_ok = (r_cmd.entry_type == '0) || (i_rd_entry.kind == r_cmd.entry_type);
    assign chk_ovl     = !((i_rd_entry.addr >= r_cmd.range_end) || (e_end <= r_point));
    assign chk_point   = (i_rd_entry.addr <= r_point) ? e_end : r_point;
    assign chk_hit     = chk_kind_ok && chk_ovl && (chk_point >= r_cmd.range_end);

    // retype and remove
    assign sw_match_kind = (r_cmd.operation == mrmt_pkg::OP_RETYPE) || r_cmd.kind_only;
    assign sw_hit = (!sw_match_kind || (i_rd_entry.kind == r_cmd.entry_type))
                 && (i_rd_entry.addr >= r_cmd.range_start) && (e_end <= r_lim);

    // end page search
    assign sp64    = i_rd_entry.addr >> mrmt_pkg::PAGE_BITS;
    assign ep64    = e_end >> mrmt_pkg::PAGE_BITS;
    assign lim64   = mrmt_pkg::ADDR_W'(r_cmd.limit_page);
    assign ep_ok   = (i_rd_entry.kind == r_cmd.entry_type) && (sp64 < lim64);
    assign ep_brk  = ep_ok && (ep64 > lim64);
    assign ep_last = (ep_ok && !ep_brk && (ep64 > mrmt_pkg::ADDR_W'(r_last)))
                   ? ep64[mrmt_pkg::PAGE_W-1:0] : r_last;
    assign pg_fin  = ep_brk ? r_cmd.limit_page : ep_last;

    assign done_w = last_ent
                 || ((r_cmd.operation == mrmt_pkg::OP_CHECK) && chk_hit)
                 || ((r_cmd.operation == mrmt_pkg::OP_ENDPAGE) && ep_brk);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mrmt_pkg::ST_IDLE: begin
                if (go_walk) begin
                    n_state = mrmt_pkg::ST_WALK;
                end
            end
            mrmt_pkg::ST_WALK: begin
                if (done_w) begin
                    n_state = mrmt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mrmt_pkg::ST_IDLE;
            end
        endcase
    end

    // ram requests
    always_comb begin
        o_ram = '0;
        case (r_state)
            mrmt_pkg::ST_IDLE: begin
                if (go_walk) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = '0;
                end
                if (accept && add_ok) begin
                    o_ram.we         = 1'b1;
                    o_ram.waddr      = r_count[mrmt_pkg::IDX_W-1:0];
                    o_ram.wdata.addr = i_cmd.range_start;
                    o_ram.wdata.len  = i_cmd.range_size;
                    o_ram.wdata.kind = i_cmd.entry_type;
                end
            end
            mrmt_pkg::ST_WALK: begin
                if (!done_w) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_eidx + mrmt_pkg::IDX_W'(1);
                end
                // write back the entry under evaluation, the read is one ahead
                if (is_sweep && sw_hit) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_eidx;
                    if (r_cmd.operation == mrmt_pkg::OP_REMOVE) begin
                        o_ram.wdata = '0;
                    end else begin
                        o_ram.wdata.addr = i_rd_entry.addr;
                        o_ram.wdata.len  = i_rd_entry.len;
                        o_ram.wdata.kind = r_cmd.repl_kind;
                    end
                end
            end
            default: begin
                o_ram = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_count = r_count;
        n_eidx  = r_eidx;
        n_cmd   = r_cmd;
        n_lim   = r_lim;
        n_point = r_point;
        n_total = r_total;
        n_last  = r_last;
        n_valid = 1'b0;
        n_res   = r_res;
        case (r_state)
            mrmt_pkg::ST_IDLE: begin
                if (accept) begin
                    n_cmd   = i_cmd;
                    n_lim   = i_cmd.range_start + i_cmd.range_size;
                    n_eidx  = '0;
                    n_point = i_cmd.range_start;
                    n_total = '0;
                    n_last  = '0;
                    n_valid = !go_walk;
                    n_res   = '0;
                    if (i_cmd.operation == mrmt_pkg::OP_ADD) begin
                        if (add_wrap) begin
                            n_res.status = mrmt_pkg::STAT_WRAP;
                        end else if (add_full) begin
                            n_res.status = mrmt_pkg::STAT_FULL;
                        end else begin
                            n_res.status = mrmt_pkg::STAT_OK;
                            n_count      = r_count + mrmt_pkg::CNT_W'(1);
                        end
                    end
                    if (i_cmd.operation == mrmt_pkg::OP_CLEAR) begin
                        n_count = '0;
                    end
                end
            end
            mrmt_pkg::ST_WALK: begin
                n_eidx = r_eidx + mrmt_pkg::IDX_W'(1);
                if (chk_kind_ok && chk_ovl) begin
                    n_point = chk_point;
                end
                n_total = r_total + (sw_hit ? i_rd_entry.len : '0);
                n_last  = ep_last;
                if (done_w) begin
                    n_valid = 1'b1;
                    n_res   = '0;
                    case (r_cmd.operation)
                        mrmt_pkg::OP_CHECK: begin
                            n_res.covered = chk_hit;
                        end
                        mrmt_pkg::OP_RETYPE, mrmt_pkg::OP_REMOVE: begin
                            n_res.total_bytes = n_total;
                        end
                        mrmt_pkg::OP_ENDPAGE: begin
                            n_res.last_page = (pg_fin > mrmt_pkg::PAGE_CAP)
                                            ? mrmt_pkg::PAGE_CAP : pg_fin;
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrmt_pkg::ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eidx  <= n_eidx;
        r_cmd   <= n_cmd;
        r_lim   <= n_lim;
        r_point <= n_point;
        r_total <= n_total;
        r_last  <= n_last;
        r_res   <= n_res;
    end

    assign o_busy  = (r_state == mrmt_pkg::ST_WALK);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/core/memory_region_map_table_unit.sv =====
// top level of the memory region map table
// depends on mrmt_pkg, mrmt_ram and mrmt_engine
//
//   channel   direction  handshake                 word
//   command   in         start && !busy            i_cmd  (mrmt_pkg::t_cmd_word)
//   result    out        o_valid, one cycle strobe o_res  (mrmt_pkg::t_res_word)
//
// add, clear and unused codes finish at once: the result strobes in the cycle
//   after the command is taken and busy never rises
// check, retype, remove and end page walk the stored entries one per cycle
//   out of the entry ram: busy through the last stored entry (earlier when a
//   check is covered early or an end page search hits its limit), the result
//   strobes in the cycle busy falls; with an empty table they finish at once
// the ram read is one entry ahead of the evaluated entry, so write-back of a
//   retyped or removed entry never meets a read of the same entry
// synchronous active low reset empties the table, entry contents are not cleared
// the receiver cannot stall: a result is shown for exactly one cycle
module memory_region_map_table_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  mrmt_pkg::t_cmd_word i_cmd,
    output logic                o_valid,
    output mrmt_pkg::t_res_word o_res
);

    // request word from the sequencer to the entry ram
    mrmt_pkg::t_ram_req ram_req;
    // entry read back, valid the cycle after a read request
    mrmt_pkg::t_entry   rd_entry;

    // entry storage: address, length and type of every slot in one word
    mrmt_ram #(
        .WIDTH (mrmt_pkg::ENTRY_W),
        .DEPTH (mrmt_pkg::MAX_REGIONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_entry)
    );

    // command decode, entry walk and result register
    mrmt_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .i_rd_entry (rd_entry),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .o_ram      (ram_req)
    );

endmodule

// ===== rtl/core/mrmt_checker.sv =====
// port level checks for the memory region map table
// depends on mrmt_pkg; bound to memory_region_map_table_unit
module mrmt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                i_busy,
    input logic                i_valid,
    input mrmt_pkg::t_res_word i_res
);

    // a result never shows while a walk is still running
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !i_busy)
        else $error("result strobe while busy");

    // a taken command gives a walk or an immediate result
    a_accept_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> (i_busy || i_valid))
        else $error("command taken without walk or result");

    // the end of a walk always delivers its result
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_busy) |-> i_valid)
        else $error("walk ended without result");

    // a full or wrap status comes with all other fields zero
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_res.status != mrmt_pkg::STAT_OK)) |->
        (!i_res.covered && (i_res.total_bytes == '0) && (i_res.last_page == '0)))
        else $error("status with other fields set");

    // end page result never exceeds the architectural cap
    a_page_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_res.last_page <= mrmt_pkg::PAGE_CAP))
        else $error("last page above cap");

endmodule

bind memory_region_map_table_unit mrmt_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_valid (o_valid),
    .i_res   (o_res)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench for memory_region_map_table_unit: directed, full-table and random operation words
// depends on mrmt_pkg and the unit; results are predicted per accepted command word
module testbench;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    // slowest case: every word a walk over a full table plus sender gaps, taken several times
    localparam longint CYCLE_LIMIT = 1_200_000;
    localparam int RANDOM_WORDS = 1580;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    mrmt_pkg::t_cmd_word i_cmd = '0;
    logic                o_valid;
    mrmt_pkg::t_res_word o_res;

    // shadow copy of the region table
    logic [mrmt_pkg::ADDR_W-1:0] map_addr [mrmt_pkg::MAX_REGIONS];
    logic [mrmt_pkg::ADDR_W-1:0] map_len  [mrmt_pkg::MAX_REGIONS];
    logic [mrmt_pkg::KIND_W-1:0] map_kind [mrmt_pkg::MAX_REGIONS];
    int                          map_count = 0;

    mrmt_pkg::t_res_word table_result_q [$];
    int                  errors = 0;
    longint              cycle_count = 0;
    bit                  idle_on = 1'b1;

    memory_region_map_table_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // applies one command word to the shadow table and returns its result word
    function automatic mrmt_pkg::t_res_word table_op_result(mrmt_pkg::t_cmd_word c);
        mrmt_pkg::t_res_word         r;
        logic [mrmt_pkg::ADDR_W-1:0] last_addr, pt, e, win_end;
        logic [mrmt_pkg::PAGE_W-1:0] pg, sp, ep;
        bit                          match_kind, stop;
        r = '0;
        case (c.operation)
            mrmt_pkg::OP_ADD: begin
                last_addr = c.range_start + c.range_size - 64'd1;
                if (c.range_size != 0 && c.range_start > last_addr) begin
                    r.status = mrmt_pkg::STAT_WRAP;
                end else if (map_count >= mrmt_pkg::MAX_REGIONS) begin
                    r.status = mrmt_pkg::STAT_FULL;
                end else begin
                    map_addr[map_count] = c.range_start;
                    map_len[map_count]  = c.range_size;
                    map_kind[map_count] = c.entry_type;
                    map_count++;
                end
            end
            mrmt_pkg::OP_CLEAR: map_count = 0;
            mrmt_pkg::OP_CHECK: begin
                pt = c.range_start;
                for (int i = 0; i < map_count && !r.covered; i++) begin
                    e = map_addr[i] + map_len[i];
                    if (c.entry_type != 0 && map_kind[i] != c.entry_type) continue;
                    if (map_addr[i] >= c.range_end || e <= pt) continue;
                    if (map_addr[i] <= pt) pt = e;
                    if (pt >= c.range_end) r.covered = 1'b1;
                end
            end
            mrmt_pkg::OP_RETYPE, mrmt_pkg::OP_REMOVE: begin
                // only entries wholly inside the range, end taken modulo 2^64
                win_end = c.range_start + c.range_size;
                match_kind = (c.operation == mrmt_pkg::OP_RETYPE) || c.kind_only;
                for (int i = 0; i < map_count; i++) begin
                    if (match_kind && map_kind[i] != c.entry_type) continue;
                    if (map_addr[i] >= c.range_start
                        && map_addr[i] + map_len[i] <= win_end) begin
                        r.total_bytes += map_len[i];
                        if (c.operation == mrmt_pkg::OP_REMOVE) begin
                            map_addr[i] = '0;
                            map_len[i]  = '0;
                            map_kind[i] = '0;
                        end else begin
                            map_kind[i] = c.repl_kind;
                        end
                    end
                end
            end
            mrmt_pkg::OP_ENDPAGE: begin
                pg = '0;
                stop = 1'b0;
                for (int i = 0; i < map_count && !stop; i++) begin
                    if (map_kind[i] != c.entry_type) continue;
                    sp = mrmt_pkg::PAGE_W'(map_addr[i] >> mrmt_pkg::PAGE_BITS);
                    ep = mrmt_pkg::PAGE_W'((map_addr[i] + map_len[i]) >> mrmt_pkg::PAGE_BITS);
                    if (sp >= c.limit_page) continue;
                    if (ep > c.limit_page) begin
                        pg = c.limit_page;
                        stop = 1'b1;
                    end else if (ep > pg) begin
                        pg = ep;
                    end
                end
                if (pg > mrmt_pkg::PAGE_CAP) pg = mrmt_pkg::PAGE_CAP;
                r.last_page = pg;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic mrmt_pkg::t_cmd_word cmd_of(logic [2:0] op, logic [63:0] s,
                                                   logic [63:0] sz, logic [63:0] e,
                                                   logic [31:0] k, logic [31:0] nk,
                                                   logic chk, logic [51:0] lim);
        mrmt_pkg::t_cmd_word c;
        c.operation   = op;
        c.range_start = s;
        c.range_size  = sz;
        c.range_end   = e;
        c.entry_type  = k;
        c.repl_kind   = nk;
        c.kind_only   = chk;
        c.limit_page  = lim;
        return c;
    endfunction

    function automatic logic [63:0] rand_wide();
        return {$urandom, $urandom};
    endfunction

    // mostly low page-aligned addresses so that entries overlap, some near the top
    function automatic logic [63:0] rand_addr();
        logic [63:0] a;
        case ($urandom_range(9))
            0: a = rand_wide();
            1: a = 64'hFFFF_FFFF_FFFF_0000 + 64'($urandom_range(0, 'hFFFF));
            default: begin
                a = 64'($urandom_range(0, 255)) << mrmt_pkg::PAGE_BITS;
                if ($urandom_range(3) == 0) a += 64'($urandom_range(0, 4095));
            end
        endcase
        return a;
    endfunction

    function automatic logic [63:0] rand_size();
        logic [63:0] s;
        case ($urandom_range(19))
            0, 1: s = '0;
            2, 3: s = rand_wide();
            4:    s = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 'hFFFF));
            default: s = 64'($urandom_range(1, 16)) << mrmt_pkg::PAGE_BITS;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] rand_kind();
        return ($urandom_range(19) < 17) ? 32'($urandom_range(0, 3)) : 32'($urandom);
    endfunction

    function automatic mrmt_pkg::t_cmd_word rand_word();
        return cmd_of(3'($urandom_range(7)), rand_wide(), rand_wide(), rand_wide(),
                      $urandom, $urandom, 1'($urandom_range(1)),
                      {20'($urandom_range(0, 20'hFFFFF)), 32'($urandom)});
    endfunction

    // holds start high until the word is taken, then predicts it
    task automatic send_cmd(input mrmt_pkg::t_cmd_word c);
        if (idle_on && $urandom_range(99) < 31) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        table_result_q.push_back(table_op_result(c));
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (table_result_q.size() != 0);
    endtask

    task automatic test_directed();
        send_cmd(cmd_of(mrmt_pkg::OP_CLEAR, '1, '1, '1, '1, '1, 1'b1, '1));
        // walks on an empty table
        send_cmd(cmd_of(mrmt_pkg::OP_CHECK, '0, '0, '0, '0, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ENDPAGE, '0, '0, '0, '0, '0, 1'b0, '1));
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, '0, '0, '0, '0, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, '1, 64'd1, '0, 32'd1, '0, 1'b0, '0));
        // wrapping adds are rejected, a zero size at the top is not
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, '1, 64'd2, '0, 32'd1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, 64'd2, '1, '0, 32'd1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, '1, '0, '0, 32'd3, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, '0, '1, '0, '1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, 64'h1000, 64'h3000, '0, 32'd1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, 64'h4000, 64'h2000, '0, 32'd1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, 64'h8000, 64'h1000, '0, 32'd2, '0, 1'b0, '0));
        // covered through two entries, a gap, empty and reversed windows, any type
        send_cmd(cmd_of(mrmt_pkg::OP_CHECK, 64'h1000, '0, 64'h6000, 32'd1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_CHECK, 64'h1000, '0, 64'h9000, 32'd1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_CHECK, 64'h2000, '0, 64'h2000, '0, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_CHECK, 64'h5000, '0, 64'h2000, '0, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_CHECK, '0, '0, '1, '1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_RETYPE, 64'h1000, 64'h5000, '0, 32'd1, '1, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_RETYPE, '0, '1, '0, '1, '0, 1'b0, '0));
        // end page: zero limit, an entry starting above the limit, type zero, widest limit
        send_cmd(cmd_of(mrmt_pkg::OP_ENDPAGE, '0, '0, '0, '0, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ENDPAGE, '0, '0, '0, 32'd2, '0, 1'b0, 52'd5));
        send_cmd(cmd_of(mrmt_pkg::OP_ENDPAGE, '0, '0, '0, '0, '0, 1'b0, '1));
        send_cmd(cmd_of(mrmt_pkg::OP_REMOVE, 64'h8000, 64'h1000, '0, 32'd2, '0, 1'b1, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_REMOVE, '0, '1, '0, '0, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_CHECK, '0, '0, '1, '0, '0, 1'b0, '0));
        send_cmd(cmd_of(OP_SPARE_LO, '1, '1, '1, '1, '1, 1'b1, '1));
        send_cmd(cmd_of(OP_SPARE_HI, '1, '1, '1, '1, '1, 1'b1, '1));
    endtask

    task automatic test_table_full();
        mrmt_pkg::t_cmd_word c;
        send_cmd(cmd_of(mrmt_pkg::OP_CLEAR, '0, '0, '0, '0, '0, 1'b0, '0));
        for (int i = 0; i < mrmt_pkg::MAX_REGIONS + 3; i++) begin
            c = rand_word();
            c.operation   = mrmt_pkg::OP_ADD;
            c.range_start = 64'($urandom_range(0, 255)) << mrmt_pkg::PAGE_BITS;
            c.range_size  = 64'($urandom_range(1, 16)) << mrmt_pkg::PAGE_BITS;
            c.entry_type  = 32'($urandom_range(0, 3));
            send_cmd(c);
            if (i % 32 == 31) begin
                c.operation  = mrmt_pkg::OP_ENDPAGE;
                c.limit_page = 52'($urandom_range(0, 300));
                send_cmd(c);
            end
        end
        // the wrap test comes before the full test
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, '1, 64'h10, '0, 32'd1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, '1, '0, '0, 32'd1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_CHECK, '0, '0, 64'h10_0000, '0, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_CHECK, '0, '0, 64'h8_0000, 32'd1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_RETYPE, 64'h4_0000, 64'h4_0000, '0, 32'd2, 32'd7,
                        1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ENDPAGE, '0, '0, '0, 32'd7, '0, 1'b0, '1));
        send_cmd(cmd_of(mrmt_pkg::OP_REMOVE, '0, '1, '0, '0, '0, 1'b0, '0));
        // zeroed entries keep their slots and are still walked
        send_cmd(cmd_of(mrmt_pkg::OP_ENDPAGE, '0, '0, '0, '0, '0, 1'b0, 52'd100));
        send_cmd(cmd_of(mrmt_pkg::OP_CHECK, '0, '0, 64'h1000, '0, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_ADD, 64'h1000, 64'h1000, '0, 32'd1, '0, 1'b0, '0));
        send_cmd(cmd_of(mrmt_pkg::OP_CLEAR, '0, '0, '0, '0, '0, 1'b0, '0));
    endtask

    task automatic test_random_ops(input int n_words);
        mrmt_pkg::t_cmd_word c;
        int                  sel, i, j;
        for (int k = 0; k < n_words; k++) begin
            // one long stretch with the sender never idling
            idle_on = !(k >= n_words / 3 && k < n_words / 3 + 300);
            if (k == n_words / 2) wait_results_drained();
            c = rand_word();
            sel = $urandom_range(99);
            i = (map_count > 0) ? $urandom_range(0, map_count - 1) : 0;
            j = (map_count > 0) ? $urandom_range(0, map_count - 1) : 0;
            if (sel < 10) begin
                // noise: every field random
            end else if (sel < 45) begin
                c.operation   = mrmt_pkg::OP_ADD;
                c.range_start = rand_addr();
                c.range_size  = rand_size();
                c.entry_type  = rand_kind();
            end else if (sel < 62) begin
                c.operation  = mrmt_pkg::OP_CHECK;
                c.entry_type = ($urandom_range(1) != 0) ? '0 : rand_kind();
                if (map_count > 0 && $urandom_range(4) != 0) begin
                    c.range_start = map_addr[i] + 64'($urandom_range(0, 2)) * 64'h800;
                    c.range_end   = map_addr[j] + map_len[j]
                                    - 64'($urandom_range(0, 1)) * 64'h800;
                    if ($urandom_range(1) != 0) c.entry_type = map_kind[i];
                end else begin
                    c.range_start = rand_addr();
                    c.range_end   = c.range_start + rand_size();
                end
            end else if (sel < 86) begin
                c.operation  = (sel < 74) ? mrmt_pkg::OP_RETYPE : mrmt_pkg::OP_REMOVE;
                c.entry_type = rand_kind();
                c.repl_kind  = rand_kind();
                if (map_count > 0 && $urandom_range(4) != 0) begin
                    c.range_start = map_addr[i] - 64'($urandom_range(0, 1)) * 64'h1000;
                    c.range_size  = map_addr[j] + map_len[j] - c.range_start
                                    + 64'($urandom_range(0, 1)) * 64'h1000;
                    if ($urandom_range(1) != 0) c.entry_type = map_kind[i];
                end else begin
                    c.range_start = rand_addr();
                    c.range_size  = rand_size();
                end
            end else if (sel < 96) begin
                c.operation  = mrmt_pkg::OP_ENDPAGE;
                c.entry_type = (map_count > 0 && $urandom_range(1) != 0) ? map_kind[i]
                                                                         : rand_kind();
                case ($urandom_range(3))
                    0: ;
                    1: c.limit_page = mrmt_pkg::PAGE_W'(map_addr[i] >> mrmt_pkg::PAGE_BITS)
                                      + 52'($urandom_range(0, 2));
                    default: c.limit_page = 52'($urandom_range(0, 300));
                endcase
            end else if (sel < 98) begin
                c.operation = mrmt_pkg::OP_CLEAR;
            end else begin
                c.operation = ($urandom_range(1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
            end
            // keep the table mostly shallow so walks stay short
            if (c.operation == mrmt_pkg::OP_ADD && map_count > 24 && $urandom_range(7) == 0)
                c.operation = mrmt_pkg::OP_CLEAR;
            send_cmd(c);
        end
    endtask

    // compares each strobed result word with the oldest prediction
    always @(posedge i_clk) begin : result_checker
        mrmt_pkg::t_res_word want;
        if (i_rst_n && o_valid) begin
            if (table_result_q.size() == 0) begin
                $display("%0t: result word with none expected, actual %h", $time, o_res);
                errors++;
            end else begin
                want = table_result_q.pop_front();
                if (o_res.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_res.status);
                    errors++;
                end
                if (o_res.covered !== want.covered) begin
                    $display("%0t: covered expected %0d actual %0d",
                             $time, want.covered, o_res.covered);
                    errors++;
                end
                if (o_res.total_bytes !== want.total_bytes) begin
                    $display("%0t: total_bytes expected %h actual %h",
                             $time, want.total_bytes, o_res.total_bytes);
                    errors++;
                end
                if (o_res.last_page !== want.last_page) begin
                    $display("%0t: last_page expected %h actual %h",
                             $time, want.last_page, o_res.last_page);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_results_drained();
        test_table_full();
        wait_results_drained();
        test_random_ops(RANDOM_WORDS);
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
